[rtl/rsw_pkg.sv]
// rsw_pkg: shared constants and codes for the roulette selection core
// no dependencies; used by rsw_alu and the top level
package rsw_pkg;

    localparam int POOL_DEPTH_DEF   = 64;
    localparam int FITNESS_BITS_DEF = 16;

    localparam int IN_FIT_BITS  = 16;
    localparam int RAND_BITS    = 16;
    localparam int OUT_IDX_BITS = 6;
    localparam int OUT_FIT_BITS = 16;

    typedef logic [1:0] mode_t;
    localparam mode_t MODE_CLEAR  = 2'd0;
    localparam mode_t MODE_LOAD   = 2'd1;
    localparam mode_t MODE_SELECT = 2'd2;

    typedef logic [0:0] alu_op_t;
    localparam alu_op_t ALU_ADD = 1'b0;
    localparam alu_op_t ALU_SUB = 1'b1;

endpackage

[rtl/rsw_alu.sv]
// rsw_alu: shared add/subtract unit of the selection sequencer
// depends on rsw_pkg for operation codes
module rsw_alu #(
    parameter int W = 22
) (
    input  rsw_pkg::alu_op_t op,
    input  logic [W-1:0]     a,
    input  logic [W-1:0]     b,
    output logic [W:0]       y
);

    always_comb begin
        unique case (op)
            rsw_pkg::ALU_SUB: y = {1'b0, a} - {1'b0, b};
            default:          y = {1'b0, a} + {1'b0, b};
        endcase
    end

endmodule

[rtl/rsw_pool_mem.sv]
// rsw_pool_mem: pool storage, one write port and one registered read port
// no package dependencies
module rsw_pool_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int DW    = 17
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] store_reg [DEPTH];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            store_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= store_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/roulette_select_without_replacement_core.sv]
// roulette_select_without_replacement_core: fitness-proportional selection
// without replacement; uses rsw_pkg, rsw_alu and rsw_pool_mem
//
// A clear or a load transaction is applied as it is accepted. A select runs
// a shift-add multiply of the RAND_BITS (16) bit fraction by the total, then
// walks the pool positions in load order, one per cycle, through the
// registered read port, then removes the chosen entry and hands the result
// to the output register; an empty pool goes straight to the output
// register, and the result is held back only while that register is full.
// Load, multiply, walk and remove share a single adder; the walk uses the
// one read port of the pool memory. The input is not ready while a select
// is in progress; a finished result waits in the output register while the
// next transaction is taken. Presence of an entry is a bit stored beside its
// fitness, and entries at or above the load count are never read.
module roulette_select_without_replacement_core #(
    parameter int POOL_DEPTH   = rsw_pkg::POOL_DEPTH_DEF,
    parameter int FITNESS_BITS = rsw_pkg::FITNESS_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // fitness_value [15:0], random_fraction [31:16]
    input  logic [1:0]  s_tuser,   // mode [1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // chosen_index [5:0], chosen_fitness [21:6], zero [23:22]
    output logic [0:0]  m_tuser    // pool_empty [0]
);

    localparam int AW  = $clog2(POOL_DEPTH);
    localparam int CW  = $clog2(POOL_DEPTH + 1);
    localparam int TW  = FITNESS_BITS + AW;
    localparam int MW  = FITNESS_BITS + 1;
    localparam int RB  = rsw_pkg::RAND_BITS;
    localparam int SCW = $clog2(RB);
    localparam int IFB = rsw_pkg::IN_FIT_BITS;
    localparam int OIB = rsw_pkg::OUT_IDX_BITS;
    localparam int OFB = rsw_pkg::OUT_FIT_BITS;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_MUL    = 3'd1;
    localparam logic [2:0] ST_WALK   = 3'd2;
    localparam logic [2:0] ST_REMOVE = 3'd3;
    localparam logic [2:0] ST_DONE   = 3'd4;

    logic [2:0]              state_reg, state_next;
    logic [TW-1:0]           total_reg, total_next;
    logic [CW-1:0]           remain_reg, remain_next;
    logic [CW-1:0]           loaded_reg, loaded_next;
    logic [TW-1:0]           acc_reg, acc_next;
    logic [RB-1:0]           frac_reg, frac_next;
    logic [SCW-1:0]          step_reg, step_next;
    logic [CW-1:0]           rd_addr_reg, rd_addr_next;
    logic                    rvld_reg, rvld_next;
    logic [AW-1:0]           rd_idx_reg, rd_idx_next;
    logic [TW-1:0]           partial_reg, partial_next;
    logic [CW-1:0]           seen_reg, seen_next;
    logic [AW-1:0]           pick_idx_reg, pick_idx_next;
    logic [FITNESS_BITS-1:0] pick_fit_reg, pick_fit_next;
    logic                    res_empty_reg, res_empty_next;
    logic                    m_tvalid_reg, m_tvalid_next;
    logic [23:0]             m_tdata_reg, m_tdata_next;
    logic                    m_tuser_reg, m_tuser_next;

    rsw_pkg::mode_t          mode;
    logic [31:0]             fit_in_wide;
    logic [31:0]             pick_idx_wide;
    logic [31:0]             pick_fit_wide;
    logic [FITNESS_BITS-1:0] load_fit;

    rsw_pkg::alu_op_t        alu_op;
    logic [TW-1:0]           alu_a, alu_b;
    logic [TW:0]             alu_y;

    logic                    mem_we, mem_re;
    logic [AW-1:0]           mem_waddr, mem_raddr;
    logic [MW-1:0]           mem_wdata, mem_rdata;
    logic                    mem_present;
    logic [FITNESS_BITS-1:0] mem_fit;

    assign mode          = s_tuser;
    assign fit_in_wide   = 32'(s_tdata[IFB-1:0]);
    assign load_fit      = fit_in_wide[FITNESS_BITS-1:0];
    assign pick_idx_wide = 32'(pick_idx_reg);
    assign pick_fit_wide = 32'(pick_fit_reg);
    assign mem_present   = mem_rdata[MW-1];
    assign mem_fit       = mem_rdata[FITNESS_BITS-1:0];

    rsw_alu #(
        .W (TW)
    ) u_alu (
        .op (alu_op),
        .a  (alu_a),
        .b  (alu_b),
        .y  (alu_y)
    );

    rsw_pool_mem #(
        .DEPTH (POOL_DEPTH),
        .AW    (AW),
        .DW    (MW)
    ) u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    always_comb begin
        state_next     = state_reg;
        total_next     = total_reg;
        remain_next    = remain_reg;
        loaded_next    = loaded_reg;
        acc_next       = acc_reg;
        frac_next      = frac_reg;
        step_next      = step_reg;
        rd_addr_next   = rd_addr_reg;
        rvld_next      = rvld_reg;
        rd_idx_next    = rd_idx_reg;
        partial_next   = partial_reg;
        seen_next      = seen_reg;
        pick_idx_next  = pick_idx_reg;
        pick_fit_next  = pick_fit_reg;
        res_empty_next = res_empty_reg;
        m_tvalid_next  = m_tvalid_reg & ~m_tready;
        m_tdata_next   = m_tdata_reg;
        m_tuser_next   = m_tuser_reg;
        mem_we         = 1'b0;
        mem_waddr      = loaded_reg[AW-1:0];
        mem_wdata      = {1'b1, load_fit};
        mem_re         = 1'b0;
        mem_raddr      = rd_addr_reg[AW-1:0];
        alu_op         = rsw_pkg::ALU_ADD;
        alu_a          = total_reg;
        alu_b          = TW'(load_fit);

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    unique case (mode)
                        rsw_pkg::MODE_CLEAR: begin
                            total_next  = '0;
                            remain_next = '0;
                            loaded_next = '0;
                        end
                        rsw_pkg::MODE_LOAD: begin
                            if (loaded_reg != CW'(POOL_DEPTH)) begin
                                mem_we      = 1'b1;
                                total_next  = alu_y[TW-1:0];
                                loaded_next = loaded_reg + 1'b1;
                                remain_next = remain_reg + 1'b1;
                            end
                        end
                        rsw_pkg::MODE_SELECT: begin
                            if (remain_reg == '0) begin
                                res_empty_next = 1'b1;
                                pick_idx_next  = '0;
                                pick_fit_next  = '0;
                                state_next     = ST_DONE;
                            end else begin
                                frac_next  = s_tdata[IFB +: RB];
                                acc_next   = '0;
                                step_next  = '0;
                                state_next = ST_MUL;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_MUL: begin
                alu_a     = acc_reg;
                alu_b     = frac_reg[0] ? total_reg : '0;
                acc_next  = alu_y[TW:1];
                frac_next = frac_reg >> 1;
                step_next = step_reg + 1'b1;
                if (step_reg == SCW'(RB - 1)) begin
                    rd_addr_next = '0;
                    rvld_next    = 1'b0;
                    partial_next = '0;
                    seen_next    = '0;
                    state_next   = ST_WALK;
                end
            end
            ST_WALK: begin
                rvld_next = 1'b0;
                if (rd_addr_reg < loaded_reg) begin
                    mem_re       = 1'b1;
                    rd_idx_next  = rd_addr_reg[AW-1:0];
                    rvld_next    = 1'b1;
                    rd_addr_next = rd_addr_reg + 1'b1;
                end
                alu_a = partial_reg;
                alu_b = TW'(mem_fit);
                if (rvld_reg && mem_present) begin
                    partial_next = alu_y[TW-1:0];
                    seen_next    = seen_reg + 1'b1;
                    if ((alu_y[TW-1:0] >= acc_reg) || (seen_reg + 1'b1 == remain_reg)) begin
                        pick_idx_next  = rd_idx_reg;
                        pick_fit_next  = mem_fit;
                        res_empty_next = 1'b0;
                        rvld_next      = 1'b0;
                        state_next     = ST_REMOVE;
                    end
                end
            end
            ST_REMOVE: begin
                mem_we      = 1'b1;
                mem_waddr   = pick_idx_reg;
                mem_wdata   = {1'b0, pick_fit_reg};
                alu_op      = rsw_pkg::ALU_SUB;
                alu_a       = total_reg;
                alu_b       = TW'(pick_fit_reg);
                total_next  = alu_y[TW-1:0];
                remain_next = remain_reg - 1'b1;
                state_next  = ST_DONE;
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {2'b00, pick_fit_wide[OFB-1:0], pick_idx_wide[OIB-1:0]};
                    m_tuser_next  = res_empty_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            total_reg    <= '0;
            remain_reg   <= '0;
            loaded_reg   <= '0;
            rvld_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            total_reg    <= total_next;
            remain_reg   <= remain_next;
            loaded_reg   <= loaded_next;
            rvld_reg     <= rvld_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // datapath registers, no reset
    always_ff @(posedge aclk) begin
        acc_reg       <= acc_next;
        frac_reg      <= frac_next;
        step_reg      <= step_next;
        rd_addr_reg   <= rd_addr_next;
        rd_idx_reg    <= rd_idx_next;
        partial_reg   <= partial_next;
        seen_reg      <= seen_next;
        pick_idx_reg  <= pick_idx_next;
        pick_fit_reg  <= pick_fit_next;
        res_empty_reg <= res_empty_next;
        m_tdata_reg   <= m_tdata_next;
        m_tuser_reg   <= m_tuser_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule
